/* sv/afs_pkg.sv */
// Shared types and constants of the ADTS frame splitter.
package afs_pkg;

    // Default width of byte positions inside the buffer.
    localparam int POSITION_BITS_DEF = 24;
    // Default depth of the queue between the parser and the result stage.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Fixed widths of the channel fields.
    localparam int POS_FIELD_W = 24;
    localparam int LEN_FIELD_W = 13;

    // Sync pattern and header layout.
    localparam logic [7:0] SYNC_BYTE = 8'hFF;
    localparam logic [7:0] SYNC_MASK = 8'hF6;
    localparam logic [7:0] SYNC_VALUE = 8'hF0;
    localparam logic [7:0] LEN_HIGH_MASK = 8'h03;
    localparam logic [LEN_FIELD_W-1:0] MIN_FRAME = 13'd7;

    typedef enum logic [1:0] {
        KIND_FRAME   = 2'd0,
        KIND_ERROR   = 2'd1,
        KIND_SUMMARY = 2'd2
    } afs_kind_t;

    // One queue entry: the results that a single byte caused.
    typedef struct packed {
        logic                   has_frame;
        logic                   frame_err;
        logic [POS_FIELD_W-1:0] offset;
        logic [LEN_FIELD_W-1:0] length;
        logic                   has_sum;
        logic [POS_FIELD_W-1:0] total;
        logic                   ok;
    } afs_op_t;

    // One result item as it leaves the block.
    typedef struct packed {
        afs_kind_t              kind;
        logic [POS_FIELD_W-1:0] offset;
        logic [LEN_FIELD_W-1:0] length;
        logic [POS_FIELD_W-1:0] total;
        logic                   ok;
        logic                   last;
    } afs_result_t;

endpackage

/* sv/afs_if.sv */
// Channel interfaces of the ADTS frame splitter: bytes in, results out, configuration.
interface afs_byte_if import afs_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface afs_result_if import afs_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [1:0]             result_kind;
    logic [POS_FIELD_W-1:0] frame_offset;
    logic [LEN_FIELD_W-1:0] frame_length;
    logic [POS_FIELD_W-1:0] frame_total;
    logic                   buffer_ok;
    logic                   last_result;

    modport source (output valid, output result_kind, output frame_offset,
                    output frame_length, output frame_total, output buffer_ok,
                    output last_result, input ready);
    modport sink (input valid, input result_kind, input frame_offset,
                  input frame_length, input frame_total, input buffer_ok,
                  input last_result, output ready);
endinterface

interface afs_cfg_if import afs_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [POS_FIELD_W-1:0] buffer_length;

    modport source (output valid, output buffer_length, input ready);
    modport sink (input valid, input buffer_length, output ready);
endinterface

/* sv/adts_frame_splitter_unit.sv */
// Top level of the ADTS frame splitter: parser, queue and result stage.
//
// The block splits a buffer of ADTS audio data into frames. Software first writes the
// buffer length on the cfg_write channel, which is always ready; a write also restarts
// the parse. The buffer's bytes then arrive in order on the bytes channel, one item per
// byte. Each frame whose header is sound yields a descriptor item (offset, length) on
// the results channel. A header with a length below seven or running past the buffer
// end yields an error item, and the rest of the buffer is only counted. The last byte
// yields a summary item with the frame count and an ok flag.
// Throughput is one byte per clock cycle: the parser takes a byte in every cycle that
// the queue has room and no length write is offered. A byte's entry is written into the
// queue when the byte is accepted; its result is then loaded into the output register
// once no earlier entry is ahead of it in the queue and the register is free.
// An entry that carries two results holds the result stage until both items are loaded.
// When the receiver stalls, the output register holds its item and the queue keeps
// taking the parser's entries; bytes stop being accepted once the queue is full, and
// also in a cycle in which a length write is offered, since that write restarts the parse.
// Reset clears the buffer length to zero, so bytes are accepted and dropped without
// any result until a length is written; the queue and output register come up empty.
module adts_frame_splitter_unit import afs_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    afs_cfg_if.sink       cfg_write,
    afs_byte_if.sink      bytes,
    afs_result_if.source  results
);

    // Parser to queue.
    logic    push;
    afs_op_t push_op;
    logic    q_full;

    // Queue to result stage.
    logic    pop;
    logic    head_valid;
    afs_op_t head_op;

    // The parser classifies each byte and pushes an entry whenever the byte
    // produced a descriptor, an error or the buffer summary.
    afs_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .bytes(bytes),
        .q_full(q_full),
        .push(push),
        .push_op(push_op)
    );

    // The queue decouples the parser from stalls of the result receiver.
    afs_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .push_op(push_op),
        .full(q_full),
        .pop(pop),
        .head_valid(head_valid),
        .head_op(head_op)
    );

    // The result stage turns each entry into one or two result items.
    afs_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .head_valid(head_valid),
        .head_op(head_op),
        .pop(pop),
        .results(results)
    );

`ifndef SYNTHESIS
    // The parser never pushes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("queue push while full");

    // The result stage pops only an entry that is present.
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue pop while empty");

    // A result that is not the last of its byte is followed by that byte's summary.
    a_split_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.ready && !results.last_result) |=>
        (results.valid && (results.result_kind == KIND_SUMMARY)))
        else $error("split entry not followed by its summary");

    // A summary without the ok flag reports no frames.
    a_summary_total: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && (results.result_kind == KIND_SUMMARY) && !results.buffer_ok)
        |-> (results.frame_total == '0))
        else $error("frame total reported on a failed buffer");
`endif

endmodule

/* sv/afs_front.sv */
// Byte parser of the ADTS frame splitter: sync hunt, header decode and frame skip.
module afs_front import afs_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    afs_cfg_if.sink         cfg_write,
    afs_byte_if.sink        bytes,
    input  logic            q_full,
    output logic            push,
    output afs_op_t         push_op
);

    localparam int PB = POSITION_BITS;
    localparam int P1W = PB + 1;
    localparam int CW = ((PB > LEN_FIELD_W) ? PB : LEN_FIELD_W) + 1;

    localparam logic [2:0] HDR_FIRST = 3'd2;
    localparam logic [2:0] HDR_LEN_HI = 3'd3;
    localparam logic [2:0] HDR_LEN_MID = 3'd4;
    localparam logic [2:0] HDR_LEN_LO = 3'd5;

    typedef enum logic [4:0] {
        PH_HUNT    = 5'b00001,
        PH_HUNT_FF = 5'b00010,
        PH_HEADER  = 5'b00100,
        PH_SKIP    = 5'b01000,
        PH_STOPPED = 5'b10000
    } phase_t;

    logic [POS_FIELD_W-1:0] cfg_len_reg, cfg_len_next;
    logic [PB-1:0]          pos_reg, pos_next;
    phase_t                 phase_reg, phase_next;
    logic [2:0]             hdr_idx_reg, hdr_idx_next;
    logic [LEN_FIELD_W-1:0] len_acc_reg, len_acc_next;
    logic [PB-1:0]          start_reg, start_next;
    logic [LEN_FIELD_W-1:0] skip_reg, skip_next;
    logic [POS_FIELD_W-1:0] found_reg, found_next;
    logic [PB-1:0]          resume_reg, resume_next;

    logic [PB-1:0]          len_buf;
    logic [7:0]             b;
    logic                   in_fire;
    logic                   at_end;
    logic                   start_fits;
    logic [LEN_FIELD_W-1:0] flen;
    logic                   flen_bad;
    logic [LEN_FIELD_W-1:0] skip_dec;
    logic                   restart;
    logic                   ok;
    afs_op_t                op;

    assign cfg_write.ready = 1'b1;
    // A length write restarts the parse, so no byte is taken in the same cycle.
    assign bytes.ready = !q_full && !cfg_write.valid;
    assign in_fire = bytes.valid && bytes.ready;
    assign b = bytes.data_byte;
    assign len_buf = PB'(cfg_len_reg);

    assign at_end = ({1'b0, pos_reg} + P1W'(1)) >= {1'b0, len_buf};
    assign start_fits = ({1'b0, pos_reg} + P1W'(MIN_FRAME - 13'd1)) <= {1'b0, len_buf};
    assign flen = len_acc_reg | {10'd0, b[7:5]};
    assign flen_bad = (flen < MIN_FRAME) ||
                      ((CW'(flen) + CW'(start_reg)) > CW'(len_buf));
    assign skip_dec = (skip_reg != '0) ? (skip_reg - 13'd1) : skip_reg;

    always_comb
    begin
        cfg_len_next = cfg_len_reg;
        pos_next = pos_reg;
        phase_next = phase_reg;
        hdr_idx_next = hdr_idx_reg;
        len_acc_next = len_acc_reg;
        start_next = start_reg;
        skip_next = skip_reg;
        found_next = found_reg;
        resume_next = resume_reg;
        restart = 1'b0;
        ok = 1'b0;
        op = '0;

        if (cfg_write.valid)
        begin
            cfg_len_next = cfg_write.buffer_length;
            restart = 1'b1;
        end
        else if (in_fire && (len_buf != '0))
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (b == SYNC_BYTE)
                    begin
                        phase_next = PH_HUNT_FF;
                    end
                end
                PH_HUNT_FF:
                begin
                    if (((b & SYNC_MASK) == SYNC_VALUE) && (pos_reg != '0) && start_fits)
                    begin
                        start_next = pos_reg - PB'(1);
                        hdr_idx_next = HDR_FIRST;
                        len_acc_next = '0;
                        phase_next = PH_HEADER;
                    end
                    else if (b != SYNC_BYTE)
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_HEADER:
                begin
                    case (hdr_idx_reg)
                        HDR_LEN_HI:
                        begin
                            len_acc_next = {b[1:0] & LEN_HIGH_MASK[1:0], 11'd0};
                        end
                        HDR_LEN_MID:
                        begin
                            len_acc_next = len_acc_reg | {2'd0, b, 3'd0};
                        end
                        HDR_LEN_LO:
                        begin
                            len_acc_next = flen;
                            op.has_frame = 1'b1;
                            op.offset = POS_FIELD_W'(start_reg);
                            op.length = flen;
                            if (flen_bad)
                            begin
                                op.frame_err = 1'b1;
                                phase_next = PH_STOPPED;
                            end
                            else
                            begin
                                found_next = found_reg + 24'd1;
                                resume_next = PB'(CW'(start_reg) + CW'(flen));
                                skip_next = flen - (MIN_FRAME - 13'd1);
                                phase_next = PH_SKIP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    hdr_idx_next = hdr_idx_reg + 3'd1;
                end
                PH_SKIP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_STOPPED:
                begin
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase

            if (at_end)
            begin
                ok = ((phase_next == PH_HUNT) || (phase_next == PH_HUNT_FF)) &&
                     (resume_next == len_buf);
                op.has_sum = 1'b1;
                op.ok = ok;
                op.total = ok ? found_next : '0;
                restart = 1'b1;
            end
            else
            begin
                pos_next = pos_reg + PB'(1);
            end
        end

        if (restart)
        begin
            pos_next = '0;
            phase_next = PH_HUNT;
            hdr_idx_next = '0;
            len_acc_next = '0;
            start_next = '0;
            skip_next = '0;
            found_next = '0;
            resume_next = '0;
        end
    end

    assign push = op.has_frame || op.has_sum;
    assign push_op = op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_len_reg <= '0;
            pos_reg <= '0;
            phase_reg <= PH_HUNT;
            hdr_idx_reg <= '0;
            len_acc_reg <= '0;
            start_reg <= '0;
            skip_reg <= '0;
            found_reg <= '0;
            resume_reg <= '0;
        end
        else
        begin
            cfg_len_reg <= cfg_len_next;
            pos_reg <= pos_next;
            phase_reg <= phase_next;
            hdr_idx_reg <= hdr_idx_next;
            len_acc_reg <= len_acc_next;
            start_reg <= start_next;
            skip_reg <= skip_next;
            found_reg <= found_next;
            resume_reg <= resume_next;
        end
    end

endmodule

/* sv/afs_queue.sv */
// Small FIFO of parsed operations between the parser and the result stage.
module afs_queue import afs_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  afs_op_t push_op,
    output logic    full,
    input  logic    pop,
    output logic    head_valid,
    output afs_op_t head_op
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    afs_op_t            mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op = mem[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

/* sv/afs_back.sv */
// Result stage: expands queued operations into result items behind an output register.
module afs_back import afs_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  afs_op_t     head_op,
    output logic        pop,
    afs_result_if.source results
);

    logic        out_valid_reg, out_valid_next;
    afs_result_t out_reg, out_next;
    logic        sum_pend_reg, sum_pend_next;
    logic        load;
    afs_result_t desc_item;
    afs_result_t sum_item;

    assign load = !out_valid_reg || results.ready;

    always_comb
    begin
        desc_item.kind = head_op.frame_err ? KIND_ERROR : KIND_FRAME;
        desc_item.offset = head_op.offset;
        desc_item.length = head_op.length;
        desc_item.total = '0;
        desc_item.ok = 1'b0;
        desc_item.last = !head_op.has_sum;

        sum_item.kind = KIND_SUMMARY;
        sum_item.offset = '0;
        sum_item.length = '0;
        sum_item.total = head_op.total;
        sum_item.ok = head_op.ok;
        sum_item.last = 1'b1;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next = out_reg;
        sum_pend_next = sum_pend_reg;
        pop = 1'b0;

        if (load)
        begin
            out_valid_next = head_valid;
            if (head_valid)
            begin
                if (sum_pend_reg || !head_op.has_frame)
                begin
                    // Second half of a split entry, or an entry with a summary only.
                    out_next = sum_item;
                    sum_pend_next = 1'b0;
                    pop = 1'b1;
                end
                else
                begin
                    out_next = desc_item;
                    sum_pend_next = head_op.has_sum;
                    pop = !head_op.has_sum;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sum_pend_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sum_pend_reg <= sum_pend_next;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.result_kind = out_reg.kind;
    assign results.frame_offset = out_reg.offset;
    assign results.frame_length = out_reg.length;
    assign results.frame_total = out_reg.total;
    assign results.buffer_ok = out_reg.ok;
    assign results.last_result = out_reg.last;

endmodule
